// File: rtl/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared sizes, command codes and sequencer states of the ancestor engine.
// ----------------------------------------------------------------------------
package lca_pkg;

	localparam int NODES     = 1024;
	localparam int LEVELS    = 10;
	localparam int ARCS      = 2 * NODES;
	localparam int NODE_W    = $clog2(NODES);
	localparam int ARC_AW    = $clog2(ARCS);
	localparam int ARC_W     = ARC_AW + 1;
	localparam int LEVEL_W   = 10;
	localparam int K_W       = $clog2(LEVELS + 1);
	localparam int TAB_DEPTH = NODES * LEVELS;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int QPTR_W    = NODE_W + 1;

	localparam logic [ARC_W-1:0] NO_ARC = '1;

	typedef enum logic [1:0] {
		F_CLEAR = 2'd0,
		F_ADD   = 2'd1,
		F_BUILD = 2'd2,
		F_QUERY = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SWEEP,
		S_ADD_RD,
		S_ADD_WR,
		S_B_INIT,
		S_B_DEQ,
		S_B_N,
		S_B_N0,
		S_B_K0,
		S_B_KRD,
		S_B_KWR,
		S_B_ARC0,
		S_B_E,
		S_B_ECHK,
		S_B_T,
		S_B_P,
		S_B_L,
		S_Q_LA,
		S_Q_LB,
		S_Q_SW,
		S_Q_LIFT,
		S_Q_LIFTW,
		S_Q_EQ,
		S_Q_DA,
		S_Q_DB,
		S_Q_DC,
		S_Q_FIN,
		S_Q_OUT
	} state_t;

endpackage

// File: rtl/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lca_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/lowest_common_ancestor_engine.sv
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine
// Tree ancestor engine: arc store, breadth-first build of a binary-lifting
// table, and lowest common ancestor queries.
// ----------------------------------------------------------------------------
// Usage. A command word (func, node_u, node_v) is taken on a rising edge where
// start is high and busy is low. Each command yields exactly one result word
// on ancestor and status, marked by done for a single cycle; the receiver
// cannot hold it off. busy falls in the same cycle as done, so a new command
// may be issued straight away.
// Flow. An add arc reads the head of the arc list and then writes the new arc;
// when the store is full it ends after the read with status set. A clear
// sweeps the arc list heads, one per cycle. A query reads both levels, lifts
// the deeper node by each set bit of the level difference, then descends the
// table from the top level; it ends early when lifting alone meets the other
// node. Its lifting and descent steps each read the ancestor table RAM, whose
// single port sets the pace. A build visits each node taken from the queue and
// each arc followed, bounded by the ports of its RAMs.
// Reset. After arst_n is released the engine empties the arc list heads with
// busy high and produces no result word. The level, ancestor and queue
// memories are not cleared; they hold meaningful data only once a build has
// written them.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [lca_pkg::NODE_W-1:0] node_u,
	input  logic [lca_pkg::NODE_W-1:0] node_v,
	output logic                      done,
	output logic [lca_pkg::NODE_W-1:0] ancestor,
	output logic                      status
);

	import lca_pkg::*;

	state_t state_q, state_d;

	func_t              op_q;
	logic               emit_q;
	logic [NODE_W-1:0]  u_q, v_q, n_q, a_q, b_q, m_q, p_q;
	logic [ARC_W-1:0]   e_q, nxt_q, arc_cnt_q;
	logic [LEVEL_W-1:0] la_q;
	logic [LEVELS-1:0]  diff_q;
	logic [K_W-1:0]     k_q;
	logic [QPTR_W-1:0]  head_q, tail_q;
	logic [NODE_W-1:0]  sweep_q;

	logic               done_q, status_q;
	logic [NODE_W-1:0]  anc_q;

	// Memory ports.
	logic                       fa_we;
	logic [NODE_W-1:0]          fa_addr;
	logic [ARC_W-1:0]           fa_wd, fa_rd;
	logic                       ar_we;
	logic [ARC_AW-1:0]          ar_addr;
	logic [ARC_W+NODE_W-1:0]    ar_wd, ar_rd;
	logic                       lv_we;
	logic [NODE_W-1:0]          lv_addr;
	logic [LEVEL_W-1:0]         lv_wd, lv_rd;
	logic                       tb_we;
	logic [NODE_W-1:0]          tb_node;
	logic [K_W-1:0]             tb_k;
	logic [TAB_AW-1:0]          tb_addr;
	logic [NODE_W-1:0]          tb_wd, tb_rd;
	logic                       qu_we;
	logic [NODE_W-1:0]          qu_addr, qu_wd, qu_rd;

	logic               fin;
	logic [NODE_W-1:0]  fin_anc;
	logic               fin_status;

	logic               accept;
	logic               arc_full;
	logic               arc_end;
	logic [LEVEL_W-1:0] lvl_diff;
	logic               swap;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign arc_full = (arc_cnt_q >= ARC_W'(ARCS));
	assign arc_end  = (e_q == NO_ARC) || (e_q >= arc_cnt_q);
	assign swap     = (la_q > lv_rd);
	assign lvl_diff = swap ? (la_q - lv_rd) : (lv_rd - la_q);
	assign tb_addr  = TAB_AW'(tb_node) * TAB_AW'(LEVELS) + TAB_AW'(tb_k);

	lca_ram #(.DEPTH(NODES), .WIDTH(ARC_W)) u_first_arc (
		.clk(clk), .we(fa_we), .addr(fa_addr), .wdata(fa_wd), .rdata(fa_rd)
	);
	lca_ram #(.DEPTH(ARCS), .WIDTH(ARC_W + NODE_W)) u_arc_store (
		.clk(clk), .we(ar_we), .addr(ar_addr), .wdata(ar_wd), .rdata(ar_rd)
	);
	lca_ram #(.DEPTH(NODES), .WIDTH(LEVEL_W)) u_level (
		.clk(clk), .we(lv_we), .addr(lv_addr), .wdata(lv_wd), .rdata(lv_rd)
	);
	lca_ram #(.DEPTH(TAB_DEPTH), .WIDTH(NODE_W)) u_table (
		.clk(clk), .we(tb_we), .addr(tb_addr), .wdata(tb_wd), .rdata(tb_rd)
	);
	lca_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_queue (
		.clk(clk), .we(qu_we), .addr(qu_addr), .wdata(qu_wd), .rdata(qu_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (func_t'(func))
						F_CLEAR: state_d = S_SWEEP;
						F_ADD:   state_d = S_ADD_RD;
						F_BUILD: state_d = S_B_INIT;
						F_QUERY: state_d = S_Q_LA;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SWEEP:   if (sweep_q == NODE_W'(NODES - 1)) state_d = S_IDLE;
			S_ADD_RD:  state_d = arc_full ? S_IDLE : S_ADD_WR;
			S_ADD_WR:  state_d = S_IDLE;
			S_B_INIT:  state_d = S_B_DEQ;
			S_B_DEQ:   state_d = (head_q < tail_q) ? S_B_N : S_IDLE;
			S_B_N:     state_d = S_B_N0;
			S_B_N0:    state_d = S_B_K0;
			S_B_K0:    state_d = (LEVELS > 1) ? S_B_KRD : S_B_ARC0;
			S_B_KRD:   state_d = S_B_KWR;
			S_B_KWR:   state_d = (k_q == K_W'(LEVELS - 1)) ? S_B_ARC0 : S_B_KRD;
			S_B_ARC0:  state_d = S_B_E;
			S_B_E:     state_d = S_B_ECHK;
			S_B_ECHK:  state_d = arc_end ? S_B_DEQ : S_B_T;
			S_B_T:     state_d = S_B_P;
			S_B_P:     state_d = S_B_L;
			S_B_L:     state_d = S_B_ECHK;
			S_Q_LA:    state_d = S_Q_LB;
			S_Q_LB:    state_d = S_Q_SW;
			S_Q_SW:    state_d = S_Q_LIFT;
			S_Q_LIFT: begin
				if (k_q == K_W'(LEVELS)) state_d = S_Q_EQ;
				else if (diff_q[0]) state_d = S_Q_LIFTW;
			end
			S_Q_LIFTW: state_d = S_Q_LIFT;
			S_Q_EQ:    state_d = (a_q == b_q) ? S_IDLE : S_Q_DA;
			S_Q_DA:    state_d = S_Q_DB;
			S_Q_DB:    state_d = S_Q_DC;
			S_Q_DC:    state_d = (k_q == '0) ? S_Q_FIN : S_Q_DA;
			S_Q_FIN:   state_d = S_Q_OUT;
			S_Q_OUT:   state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory controls and completion.
	always_comb begin
		fa_we = 1'b0; fa_addr = u_q; fa_wd = NO_ARC;
		ar_we = 1'b0; ar_addr = e_q[ARC_AW-1:0]; ar_wd = {fa_rd, v_q};
		lv_we = 1'b0; lv_addr = n_q; lv_wd = '0;
		tb_we = 1'b0; tb_node = n_q; tb_k = '0; tb_wd = n_q;
		qu_we = 1'b0; qu_addr = head_q[NODE_W-1:0]; qu_wd = u_q;
		fin = 1'b0; fin_anc = '0; fin_status = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				fa_we   = 1'b1;
				fa_addr = sweep_q;
				fin     = emit_q && (sweep_q == NODE_W'(NODES - 1));
			end
			S_ADD_RD: begin
				fin        = arc_full;
				fin_status = arc_full;
			end
			S_ADD_WR: begin
				ar_we   = 1'b1;
				ar_addr = arc_cnt_q[ARC_AW-1:0];
				fa_we   = 1'b1;
				fa_wd   = arc_cnt_q;
				fin     = 1'b1;
			end
			S_B_INIT: begin
				lv_we   = 1'b1;
				lv_addr = u_q;
				tb_we   = 1'b1;
				tb_node = u_q;
				tb_wd   = u_q;
				qu_we   = 1'b1;
				qu_addr = '0;
			end
			S_B_DEQ:  fin = (head_q >= tail_q);
			S_B_KRD: begin
				tb_node = a_q;
				tb_k    = k_q - 1'b1;
			end
			S_B_KWR: begin
				tb_we = 1'b1;
				tb_k  = k_q;
				tb_wd = tb_rd;
			end
			S_B_ARC0: fa_addr = n_q;
			S_B_L: begin
				if (m_q != p_q) begin
					lv_we   = 1'b1;
					lv_addr = m_q;
					lv_wd   = lv_rd + 1'b1;
					tb_we   = 1'b1;
					tb_node = m_q;
					qu_we   = (tail_q < QPTR_W'(NODES));
					qu_addr = tail_q[NODE_W-1:0];
					qu_wd   = m_q;
				end
			end
			S_Q_LA:   lv_addr = u_q;
			S_Q_LB:   lv_addr = v_q;
			S_Q_LIFT: begin
				tb_node = b_q;
				tb_k    = k_q;
			end
			S_Q_EQ: begin
				fin     = (a_q == b_q);
				fin_anc = a_q;
			end
			S_Q_DA: begin
				tb_node = a_q;
				tb_k    = k_q;
			end
			S_Q_DB: begin
				tb_node = b_q;
				tb_k    = k_q;
			end
			S_Q_FIN:  tb_node = a_q;
			S_Q_OUT: begin
				fin     = 1'b1;
				fin_anc = tb_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			emit_q    <= 1'b0;
			sweep_q   <= '0;
			arc_cnt_q <= '0;
			done_q    <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			k_q       <= '0;
			op_q      <= F_CLEAR;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (fin) begin
				anc_q    <= fin_anc;
				status_q <= fin_status;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= func_t'(func);
						u_q     <= node_u;
						v_q     <= node_v;
						emit_q  <= 1'b1;
						sweep_q <= '0;
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == NODE_W'(NODES - 1)) arc_cnt_q <= '0;
				end
				S_ADD_WR: arc_cnt_q <= arc_cnt_q + 1'b1;
				S_B_INIT: begin
					head_q <= '0;
					tail_q <= QPTR_W'(1);
				end
				S_B_DEQ:  if (head_q < tail_q) head_q <= head_q + 1'b1;
				S_B_N:    n_q <= qu_rd;
				S_B_K0: begin
					a_q <= tb_rd;
					k_q <= K_W'(1);
				end
				S_B_KWR: begin
					a_q <= tb_rd;
					k_q <= k_q + 1'b1;
				end
				S_B_E:    e_q <= fa_rd;
				S_B_T: begin
					m_q   <= ar_rd[NODE_W-1:0];
					nxt_q <= ar_rd[ARC_W+NODE_W-1:NODE_W];
				end
				S_B_P:    p_q <= tb_rd;
				S_B_L: begin
					e_q <= nxt_q;
					if ((m_q != p_q) && (tail_q < QPTR_W'(NODES))) begin
						tail_q <= tail_q + 1'b1;
					end
				end
				S_Q_LB:   la_q <= lv_rd;
				S_Q_SW: begin
					a_q    <= swap ? v_q : u_q;
					b_q    <= swap ? u_q : v_q;
					diff_q <= LEVELS'(lvl_diff);
					k_q    <= '0;
				end
				S_Q_LIFT: begin
					if ((k_q != K_W'(LEVELS)) && !diff_q[0]) begin
						k_q    <= k_q + 1'b1;
						diff_q <= diff_q >> 1;
					end
				end
				S_Q_LIFTW: begin
					b_q    <= tb_rd;
					k_q    <= k_q + 1'b1;
					diff_q <= diff_q >> 1;
				end
				S_Q_EQ:   k_q <= K_W'(LEVELS - 1);
				S_Q_DB:   p_q <= tb_rd;
				S_Q_DC: begin
					if (p_q != tb_rd) begin
						a_q <= p_q;
						b_q <= tb_rd;
					end
					if (k_q != '0) k_q <= k_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign done     = done_q;
	assign ancestor = anc_q;
	assign status   = status_q;

	// A result word never follows another in the next cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back result words");

	// An accepted command keeps the engine busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("engine idle after accept");

	// A full-store flag is only ever raised by an add arc command.
	a_status_add: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (op_q == F_ADD)) else $error("stray status");

	// Only queries return a non-zero ancestor.
	a_anc_query: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (op_q != F_QUERY)) |-> (ancestor == '0))
		else $error("ancestor set on a non-query command");

	// The arc count never passes the store size.
	a_arc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		arc_cnt_q <= ARC_W'(ARCS)) else $error("arc count overflow");

endmodule
